### design/keypress_led_effect_controller_macros.svh
// Assertion macros for the key LED effect controller checker.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef KEYPRESS_LED_EFFECT_CONTROLLER_MACROS_SVH
`define KEYPRESS_LED_EFFECT_CONTROLLER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define KLED_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define KLED_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/kled_pkg.sv
// Shared types and constants for the key LED effect controller.
// No dependencies; used by kled_cell, kled_checker and the top level of the block.
package kled_pkg;

    localparam int LED_COUNT_DEFAULT = 3;

    localparam logic [7:0]  WHITE_LEVEL       = 8'h7f;
    localparam logic [7:0]  RAND_BASE         = 8'h6f;
    localparam logic [7:0]  RANDOM_STOP_LEVEL = 8'h0f;
    localparam logic [15:0] FADE_PERIOD_RESET = 16'd2;

    typedef enum logic [2:0] {
        OP_SET     = 3'd0,
        OP_ARM     = 3'd1,
        OP_PRESS   = 3'd2,
        OP_RELEASE = 3'd3,
        OP_FADE    = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        MODE_OFF         = 3'd0,
        MODE_LIGHT_HELD  = 3'd1,
        MODE_WHITE_FADE  = 3'd2,
        MODE_RANDOM_FADE = 3'd3,
        MODE_DARK_HELD   = 3'd4
    } mode_t;

    typedef enum logic {
        CFG_EFFECT_MODE = 1'b0,
        CFG_FADE_PERIOD = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] red;
        logic [7:0] green;
    } color_t;

    typedef struct packed {
        logic        take;
        op_t         op;
        mode_t       mode;
        logic        active;
        logic [15:0] fade_period;
        color_t      color;
        logic [5:0]  rand_blue;
        logic [5:0]  rand_red;
        logic [5:0]  rand_green;
    } cell_cmd_t;

endpackage

### design/kled_if.sv
// Handshake channels of the key LED effect controller: events in, LED states out.
// No dependencies.
interface kled_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] op;
    logic [1:0] key;
    logic [7:0] blue;
    logic [7:0] red;
    logic [7:0] green;
    logic [5:0] rand_blue;
    logic [5:0] rand_red;
    logic [5:0] rand_green;

    modport source (output valid, op, key, blue, red, green, rand_blue, rand_red, rand_green,
                    input ready);
    modport sink (input valid, op, key, blue, red, green, rand_blue, rand_red, rand_green,
                  output ready);
endinterface

interface kled_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] led0_blue;
    logic [7:0] led0_red;
    logic [7:0] led0_green;
    logic [7:0] led1_blue;
    logic [7:0] led1_red;
    logic [7:0] led1_green;
    logic [7:0] led2_blue;
    logic [7:0] led2_red;
    logic [7:0] led2_green;
    logic       refresh;

    modport source (output valid, led0_blue, led0_red, led0_green, led1_blue, led1_red,
                    led1_green, led2_blue, led2_red, led2_green, refresh,
                    input ready);
    modport sink (input valid, led0_blue, led0_red, led0_green, led1_blue, led1_red,
                  led1_green, led2_blue, led2_red, led2_green, refresh,
                  output ready);
endinterface

### design/keypress_led_effect_controller.sv
// Key LED effect controller: one event is accepted per cycle while the result register is
// empty or its result is taken, and the result (the colours of LEDs 0 to 2 and the refresh
// flag) appears in the single output register on the next cycle, where it is held until taken.
// Every event gives exactly one result. An event is taken while a result waits only if that
// result is taken in the same cycle. The user must write the effect mode and fade period
// through the configuration port only while no event is in flight (not enforced by the block).
// Depends on kled_pkg, kled_if and kled_cell.
module keypress_led_effect_controller
    import kled_pkg::*;
#(
    parameter int LED_COUNT = LED_COUNT_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    kled_in_if.sink     event_ch,
    kled_out_if.source  result_ch,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int OUT_LEDS = 3;

    logic [2:0]  mode_reg;
    logic [15:0] period_reg;
    logic        take;
    logic        key_ok;
    logic        refresh_next;
    logic        out_valid_reg;
    logic        refresh_reg;
    cell_cmd_t   cmd;
    color_t      shown_next [LED_COUNT];
    logic [LED_COUNT-1:0] fade_refresh;
    color_t      led_reg [OUT_LEDS];

    assign event_ch.ready = !out_valid_reg || result_ch.ready;
    assign take   = event_ch.valid && event_ch.ready;
    assign key_ok = 32'(event_ch.key) < LED_COUNT;

    always_comb
    begin
        cmd.take        = take;
        cmd.op          = op_t'(event_ch.op);
        cmd.mode        = mode_t'(mode_reg);
        cmd.active      = (mode_reg >= MODE_LIGHT_HELD) && (mode_reg <= MODE_DARK_HELD);
        cmd.fade_period = period_reg;
        cmd.color       = '{blue: event_ch.blue, red: event_ch.red, green: event_ch.green};
        cmd.rand_blue   = event_ch.rand_blue;
        cmd.rand_red    = event_ch.rand_red;
        cmd.rand_green  = event_ch.rand_green;
    end

    for (genvar k = 0; k < LED_COUNT; k++)
    begin : g_cell
        kled_cell u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .cmd          (cmd),
            .hit          (32'(event_ch.key) == k),
            .shown_next   (shown_next[k]),
            .fade_refresh (fade_refresh[k])
        );
    end

    always_comb
    begin
        case (cmd.op)
            OP_ARM:
            begin
                refresh_next = cmd.active;
            end
            OP_PRESS:
            begin
                refresh_next = cmd.active && key_ok;
            end
            OP_RELEASE:
            begin
                refresh_next = key_ok && ((cmd.mode == MODE_LIGHT_HELD)
                    || (cmd.mode == MODE_DARK_HELD));
            end
            OP_FADE:
            begin
                refresh_next = |fade_refresh;
            end
            default:
            begin
                refresh_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_OFF;
            period_reg <= FADE_PERIOD_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_EFFECT_MODE:
                begin
                    mode_reg <= cfg_data[2:0];
                end
                default:
                begin
                    period_reg <= cfg_data;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    for (genvar k = 0; k < OUT_LEDS; k++)
    begin : g_out
        if (k < LED_COUNT)
        begin : g_used
            always_ff @(posedge clk)
            begin
                if (take)
                begin
                    led_reg[k] <= shown_next[k];
                end
            end
        end
        else
        begin : g_unused
            always_ff @(posedge clk)
            begin
                led_reg[k] <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            refresh_reg <= refresh_next;
        end
    end

    assign result_ch.valid      = out_valid_reg;
    assign result_ch.refresh    = refresh_reg;
    assign result_ch.led0_blue  = led_reg[0].blue;
    assign result_ch.led0_red   = led_reg[0].red;
    assign result_ch.led0_green = led_reg[0].green;
    assign result_ch.led1_blue  = led_reg[1].blue;
    assign result_ch.led1_red   = led_reg[1].red;
    assign result_ch.led1_green = led_reg[1].green;
    assign result_ch.led2_blue  = led_reg[2].blue;
    assign result_ch.led2_red   = led_reg[2].red;
    assign result_ch.led2_green = led_reg[2].green;

endmodule

### design/kled_cell.sv
// State and next-state logic of one key LED: shown and saved colour, fade flag, countdown.
// Depends on kled_pkg.
module kled_cell
    import kled_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cell_cmd_t cmd,
    input  logic      hit,
    output color_t    shown_next,
    output logic      fade_refresh
);

    color_t      shown_reg;
    color_t      saved_reg;
    color_t      saved_next;
    logic        fading_reg;
    logic        fading_next;
    logic [15:0] count_reg;
    logic [15:0] count_next;
    logic        stop;
    logic        fade_mode;

    always_comb
    begin
        stop      = 1'b0;
        fade_mode = 1'b0;
        case (cmd.mode)
            MODE_WHITE_FADE:
            begin
                fade_mode = 1'b1;
                stop = (shown_reg.blue == 8'd0) || (shown_reg.red == 8'd0)
                    || (shown_reg.green == 8'd0);
            end
            MODE_RANDOM_FADE:
            begin
                fade_mode = 1'b1;
                stop = (shown_reg.blue <= RANDOM_STOP_LEVEL)
                    || (shown_reg.red <= RANDOM_STOP_LEVEL)
                    || (shown_reg.green <= RANDOM_STOP_LEVEL);
            end
            default:
            begin
                fade_mode = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        shown_next   = shown_reg;
        saved_next   = saved_reg;
        fading_next  = fading_reg;
        count_next   = count_reg;
        fade_refresh = 1'b0;
        if (cmd.take)
        begin
            case (cmd.op)
                OP_SET:
                begin
                    if (hit)
                    begin
                        shown_next = cmd.color;
                    end
                end
                OP_ARM:
                begin
                    if (cmd.active)
                    begin
                        saved_next = shown_reg;
                        if (cmd.mode != MODE_DARK_HELD)
                        begin
                            shown_next = '0;
                        end
                    end
                end
                OP_PRESS:
                begin
                    if (cmd.active && hit)
                    begin
                        case (cmd.mode)
                            MODE_LIGHT_HELD:
                            begin
                                shown_next = saved_reg;
                            end
                            MODE_WHITE_FADE:
                            begin
                                shown_next  = '{blue: WHITE_LEVEL, red: WHITE_LEVEL,
                                                green: WHITE_LEVEL};
                                fading_next = 1'b0;
                            end
                            MODE_RANDOM_FADE:
                            begin
                                shown_next.blue  = {2'b00, cmd.rand_blue} + RAND_BASE;
                                shown_next.red   = {2'b00, cmd.rand_red} + RAND_BASE;
                                shown_next.green = {2'b00, cmd.rand_green} + RAND_BASE;
                                fading_next      = 1'b0;
                            end
                            default:
                            begin
                                shown_next = '0;
                            end
                        endcase
                    end
                end
                OP_RELEASE:
                begin
                    if (cmd.active && hit)
                    begin
                        case (cmd.mode)
                            MODE_LIGHT_HELD:
                            begin
                                shown_next = '0;
                            end
                            MODE_DARK_HELD:
                            begin
                                shown_next = saved_reg;
                            end
                            default:
                            begin
                                fading_next = 1'b1;
                            end
                        endcase
                    end
                end
                OP_FADE:
                begin
                    if (fading_reg && fade_mode)
                    begin
                        if (stop)
                        begin
                            fading_next  = 1'b0;
                            shown_next   = '0;
                            fade_refresh = 1'b1;
                        end
                        else if (count_reg != 16'd0)
                        begin
                            count_next = count_reg - 16'd1;
                        end
                        else
                        begin
                            count_next       = cmd.fade_period;
                            shown_next.blue  = shown_reg.blue - 8'd1;
                            shown_next.red   = shown_reg.red - 8'd1;
                            shown_next.green = shown_reg.green - 8'd1;
                            fade_refresh     = 1'b1;
                        end
                    end
                end
                default:
                begin
                    shown_next = shown_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shown_reg  <= '0;
            saved_reg  <= '0;
            fading_reg <= 1'b0;
            count_reg  <= FADE_PERIOD_RESET;
        end
        else
        begin
            shown_reg  <= shown_next;
            saved_reg  <= saved_next;
            fading_reg <= fading_next;
            count_reg  <= count_next;
        end
    end

endmodule

### design/kled_checker.sv
// Port-level checks of the key LED effect controller, bound to the top level.
// Depends on kled_pkg and keypress_led_effect_controller_macros.svh.
`include "keypress_led_effect_controller_macros.svh"

module kled_checker
    import kled_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       ev_valid,
    input logic       ev_ready,
    input logic [2:0] ev_op,
    input logic       res_valid,
    input logic       res_ready,
    input logic       res_refresh,
    input logic [7:0] res_led0_blue
);

    logic ev_take;
    logic res_stall;

    assign ev_take   = ev_valid && ev_ready;
    assign res_stall = res_valid && !res_ready;

    `KLED_ASSERT_NEXT(a_result_follows, ev_take, res_valid, "accepted event gave no result")
    `KLED_ASSERT_SAME(a_no_overrun, res_stall, !ev_ready, "event accepted over a waiting result")
    `KLED_ASSERT_NEXT(a_no_spurious, !ev_take && !res_stall, !res_valid, "result without event")
    `KLED_ASSERT_NEXT(a_set_quiet, ev_take && (ev_op == OP_SET), !res_refresh, "set colour refreshed")
    `KLED_ASSERT_NEXT(a_stall_hold, res_stall, res_valid && $stable(res_led0_blue), "stalled result changed")

endmodule

bind keypress_led_effect_controller kled_checker u_kled_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .ev_valid      (event_ch.valid),
    .ev_ready      (event_ch.ready),
    .ev_op         (event_ch.op),
    .res_valid     (result_ch.valid),
    .res_ready     (result_ch.ready),
    .res_refresh   (result_ch.refresh),
    .res_led0_blue (result_ch.led0_blue)
);
